// File: sv/sdmb_pkg.sv
// Shared types and constants for the soft disc max-blend pixel pipeline.
// No dependencies; every other file of the block but sdmb_isqrt uses this package.
`default_nettype none

package sdmb_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_DIM_DEF   = 2048;
    localparam int FRAC_BITS_DEF = 8;

    // Fixed field widths
    localparam int ROW_W = 11;
    localparam int COL_W = 11;
    localparam int PIX_W = 8;
    localparam int CX_W  = 19;
    localparam int CY_W  = 19;
    localparam int RAD_W = 18;
    localparam int DIM_W = 12;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(2048);

    // Configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_CENTER_X     = 3'd0,
        REG_CENTER_Y     = 3'd1,
        REG_RADIUS       = 3'd2,
        REG_IMAGE_WIDTH  = 3'd3,
        REG_IMAGE_HEIGHT = 3'd4
    } reg_idx_t;

    // Disc geometry as seen by the datapath
    typedef struct packed {
        logic [CX_W-1:0]  center_x;
        logic [CY_W-1:0]  center_y;
        logic [RAD_W-1:0] radius;
    } cfg_t;

    // Clamped bounding box; upper bounds exclusive
    typedef struct packed {
        logic [DIM_W-1:0] row_lo;
        logic [DIM_W-1:0] row_hi;
        logic [DIM_W-1:0] col_lo;
        logic [DIM_W-1:0] col_hi;
    } box_t;

endpackage

`default_nettype wire

// File: sv/sdmb_if.sv
// Valid/ready stream interfaces for the pixel input and output channels.
// Depends on sdmb_pkg for the field widths.
`default_nettype none

interface sdmb_pix_in_if;
    logic                       valid;
    logic                       ready;
    logic [sdmb_pkg::ROW_W-1:0] pixel_row;
    logic [sdmb_pkg::COL_W-1:0] pixel_col;
    logic [sdmb_pkg::PIX_W-1:0] old_value;

    modport source (output valid, output pixel_row, output pixel_col, output old_value,
                    input ready);
    modport sink   (input valid, input pixel_row, input pixel_col, input old_value,
                    output ready);
endinterface

interface sdmb_pix_out_if;
    logic                       valid;
    logic                       ready;
    logic [sdmb_pkg::PIX_W-1:0] new_value;

    modport source (output valid, output new_value, input ready);
    modport sink   (input valid, input new_value, output ready);
endinterface

`default_nettype wire

// File: sv/soft_disc_max_blend.sv
// Soft disc max-blend: per-pixel antialiased disc drawn over an 8-bit stream.
// Depends on sdmb_pkg, sdmb_if, sdmb_cfg, sdmb_isqrt and sdmb_outbuf.
// Throughput one pixel per cycle while the skid entry is empty. A pixel passes stages 1-4,
// the distance root, stage 5, the intensity root, stage 6 and then the output register.
// A single global enable stalls every stage while the skid entry is full.
// rst_n clears all valid bits and loads the register reset values; no clearing pass.
`default_nettype none

module soft_disc_max_blend #(
    parameter int MAX_DIM   = sdmb_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = sdmb_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sdmb_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [sdmb_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [sdmb_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    sdmb_pix_in_if.sink                          pix_in,
    sdmb_pix_out_if.source                       pix_out
);

    localparam int F      = FRAC_BITS;
    localparam int PIX_W  = sdmb_pkg::PIX_W;
    localparam int DIM_W  = sdmb_pkg::DIM_W;
    // Magnitude of a Q offset: pixel index in Q form or the centre, whichever is wider
    localparam int MAG_W  = (sdmb_pkg::ROW_W + F > sdmb_pkg::CX_W) ?
                            sdmb_pkg::ROW_W + F : sdmb_pkg::CX_W;
    localparam int DX_W   = MAG_W + 1;
    localparam int SQ_W   = 2 * MAG_W + 1;
    localparam int D_W    = (SQ_W + 1) / 2;
    localparam int DIFF_W = ((sdmb_pkg::RAD_W > D_W) ? sdmb_pkg::RAD_W : D_W) + 2;
    localparam int U_W    = F + 1;
    localparam int USQ_W  = U_W + F + 8;
    localparam int S_W    = (USQ_W + 1) / 2;
    localparam int PROD_W = S_W + 8;
    localparam int BQ_W   = PROD_W - (F + 4);
    localparam int SIDE_W = 1 + PIX_W;
    localparam logic [U_W-1:0] ONE_U = U_W'(1) << F;

    sdmb_pkg::cfg_t cfg;
    sdmb_pkg::box_t box;
    logic           en;

    // Register file and box edges
    sdmb_cfg #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .box     (box)
    );

    // Stage 1: capture the transfer
    logic                       s1_valid_reg;
    logic [sdmb_pkg::ROW_W-1:0] s1_row_reg;
    logic [sdmb_pkg::COL_W-1:0] s1_col_reg;
    logic [PIX_W-1:0]           s1_old_reg;

    assign pix_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= pix_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_row_reg <= pix_in.pixel_row;
            s1_col_reg <= pix_in.pixel_col;
            s1_old_reg <= pix_in.old_value;
        end
    end

    // Stage 2: box test and signed offsets from the centre
    logic                   s2_valid_reg;
    logic                   s2_in_box_reg;
    logic [PIX_W-1:0]       s2_old_reg;
    logic signed [DX_W-1:0] s2_dx_reg;
    logic signed [DX_W-1:0] s2_dy_reg;
    logic                   s2_in_box_next;
    logic signed [DX_W-1:0] s2_dx_next;
    logic signed [DX_W-1:0] s2_dy_next;

    always_comb
    begin
        logic [DIM_W-1:0] row_e;
        logic [DIM_W-1:0] col_e;
        logic [MAG_W-1:0] row_fx;
        logic [MAG_W-1:0] col_fx;
        row_e  = DIM_W'(s1_row_reg);
        col_e  = DIM_W'(s1_col_reg);
        row_fx = MAG_W'({s1_row_reg, {F{1'b0}}});
        col_fx = MAG_W'({s1_col_reg, {F{1'b0}}});
        // upper edges are exclusive
        s2_in_box_next = (row_e >= box.row_lo) && (row_e < box.row_hi) &&
                         (col_e >= box.col_lo) && (col_e < box.col_hi);
        s2_dx_next = $signed({1'b0, col_fx}) - $signed({1'b0, MAG_W'(cfg.center_x)});
        s2_dy_next = $signed({1'b0, row_fx}) - $signed({1'b0, MAG_W'(cfg.center_y)});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_in_box_reg <= s2_in_box_next;
            s2_old_reg    <= s1_old_reg;
            s2_dx_reg     <= s2_dx_next;
            s2_dy_reg     <= s2_dy_next;
        end
    end

    // Stage 3: squares, one multiplier per axis
    logic                     s3_valid_reg;
    logic [SIDE_W-1:0]        s3_side_reg;
    logic [2*MAG_W-1:0]       s3_sqx_reg;
    logic [2*MAG_W-1:0]       s3_sqy_reg;
    logic signed [2*DX_W-1:0] sqx_full;
    logic signed [2*DX_W-1:0] sqy_full;

    assign sqx_full = s2_dx_reg * s2_dx_reg;
    assign sqy_full = s2_dy_reg * s2_dy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (en)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_side_reg <= {s2_in_box_reg, s2_old_reg};
            s3_sqx_reg  <= sqx_full[2*MAG_W-1:0];
            s3_sqy_reg  <= sqy_full[2*MAG_W-1:0];
        end
    end

    // Stage 4: squared distance
    logic              s4_valid_reg;
    logic [SIDE_W-1:0] s4_side_reg;
    logic [SQ_W-1:0]   s4_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (en)
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_side_reg <= s3_side_reg;
            s4_sum_reg  <= SQ_W'(s3_sqx_reg) + SQ_W'(s3_sqy_reg);
        end
    end

    // Distance d = floor(sqrt(dx^2 + dy^2)), one bit per stage
    logic              d_valid;
    logic [D_W-1:0]    d_root;
    logic [SIDE_W-1:0] d_side;
    logic [SIDE_W-1:0] s4_side;

    assign s4_side = s4_side_reg;

    sdmb_isqrt #(
        .IN_W   (SQ_W),
        .SIDE_W (SIDE_W)
    ) u_dist_root (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (s4_valid_reg),
        .in_radicand (s4_sum_reg),
        .in_side     (s4_side),
        .out_valid   (d_valid),
        .out_root    (d_root),
        .out_side    (d_side)
    );

    // Stage 5: edge coverage u = clamp(2*(r - d), 0, one)
    logic              s5_valid_reg;
    logic [SIDE_W-1:0] s5_side_reg;
    logic [U_W-1:0]    s5_u_reg;
    logic [U_W-1:0]    s5_u_next;

    always_comb
    begin
        logic signed [DIFF_W-1:0] diff;
        logic signed [DIFF_W-1:0] dbl;
        diff = $signed(DIFF_W'(cfg.radius)) - $signed(DIFF_W'(d_root));
        dbl  = diff <<< 1;
        if (diff <= 0)
            s5_u_next = '0;
        else if (dbl > $signed(DIFF_W'(ONE_U)))
            s5_u_next = ONE_U;
        else
            s5_u_next = dbl[U_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else if (en)
            s5_valid_reg <= d_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_side_reg <= d_side;
            s5_u_reg    <= s5_u_next;
        end
    end

    // Intensity root s = floor(sqrt(u << (FRAC_BITS + 8)))
    logic              s_valid;
    logic [S_W-1:0]    s_root;
    logic [SIDE_W-1:0] s_side;
    logic [USQ_W-1:0]  u_shifted;

    assign u_shifted = {s5_u_reg, {(F + 8){1'b0}}};

    sdmb_isqrt #(
        .IN_W   (USQ_W),
        .SIDE_W (SIDE_W)
    ) u_level_root (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (s5_valid_reg),
        .in_radicand (u_shifted),
        .in_side     (s5_side_reg),
        .out_valid   (s_valid),
        .out_root    (s_root),
        .out_side    (s_side)
    );

    // Stage 6: b = floor(255 * s / 2^(FRAC_BITS+4)), then max against the old value
    logic             s6_valid_reg;
    logic [PIX_W-1:0] s6_new_reg;
    logic [PIX_W-1:0] s6_new_next;

    always_comb
    begin
        logic [PROD_W-1:0] prod;
        logic [BQ_W-1:0]   bq;
        logic [PIX_W-1:0]  b;
        logic [PIX_W-1:0]  old;
        prod = {s_root, 8'b0} - PROD_W'(s_root);
        bq   = prod[PROD_W-1 -: BQ_W];
        b    = (bq > BQ_W'({PIX_W{1'b1}})) ? {PIX_W{1'b1}} : bq[PIX_W-1:0];
        old  = s_side[PIX_W-1:0];
        // outside the box the pixel passes through
        s6_new_next = (s_side[PIX_W] && (b > old)) ? b : old;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_valid_reg <= 1'b0;
        else if (en)
            s6_valid_reg <= s_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s6_new_reg <= s6_new_next;
    end

    // Output register and skid entry; hold the whole pipeline while the skid is full
    sdmb_outbuf u_outbuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .pipe_valid (s6_valid_reg),
        .pipe_value (s6_new_reg),
        .en         (en),
        .pix_out    (pix_out)
    );

    a_cover_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        s5_valid_reg |-> (s5_u_reg <= ONE_U))
        else $error("edge coverage above one pixel");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(s6_valid_reg) && $stable(s1_valid_reg))
        else $error("pipeline moved during a stall");

endmodule

`default_nettype wire

// File: sv/sdmb_cfg.sv
// APB register file for the disc geometry and image size, plus the registered bounding box.
// Depends on sdmb_pkg.
`default_nettype none

module sdmb_cfg #(
    parameter int MAX_DIM   = sdmb_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = sdmb_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sdmb_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [sdmb_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [sdmb_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    output sdmb_pkg::cfg_t                       cfg,
    output sdmb_pkg::box_t                       box
);

    localparam int DIM_W = sdmb_pkg::DIM_W;
    localparam int SUM_W = sdmb_pkg::CX_W + 2;
    localparam int DIM_CAP_I = (MAX_DIM < (2 ** DIM_W) - 1) ? MAX_DIM : (2 ** DIM_W) - 1;
    localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(DIM_CAP_I);
    localparam logic signed [SUM_W-1:0] ONE_FX = SUM_W'(1) << FRAC_BITS;

    logic [sdmb_pkg::CX_W-1:0]  center_x_reg;
    logic [sdmb_pkg::CY_W-1:0]  center_y_reg;
    logic [sdmb_pkg::RAD_W-1:0] radius_reg;
    logic [DIM_W-1:0]           image_width_reg;
    logic [DIM_W-1:0]           image_height_reg;
    sdmb_pkg::box_t             box_reg;
    sdmb_pkg::box_t             box_next;

    sdmb_pkg::reg_idx_t idx;
    logic               wr_en;

    // Largest usable index along one axis, with the size saturated to 1..MAX_DIM
    function automatic logic [DIM_W-1:0] last_index(input logic [DIM_W-1:0] dim);
        logic [DIM_W-1:0] lim;
        if (dim == '0)
            lim = '0;
        else if (dim > DIM_CAP)
            lim = DIM_CAP - DIM_W'(1);
        else
            lim = dim - DIM_W'(1);
        return lim;
    endfunction

    // Drop the fraction of a Q position and clamp it to 0..lim
    function automatic logic [DIM_W-1:0] box_edge(input logic signed [SUM_W-1:0] x,
                                                  input logic [DIM_W-1:0] lim);
        logic [SUM_W-1:0] q;
        logic [DIM_W-1:0] e;
        q = SUM_W'(x >>> FRAC_BITS);
        if (x[SUM_W-1])
            e = '0;
        else if (q > SUM_W'(lim))
            e = lim;
        else
            e = q[DIM_W-1:0];
        return e;
    endfunction

    assign idx    = sdmb_pkg::reg_idx_t'(paddr[sdmb_pkg::APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg     <= '0;
            center_y_reg     <= '0;
            radius_reg       <= '0;
            image_width_reg  <= sdmb_pkg::DIM_RESET;
            image_height_reg <= sdmb_pkg::DIM_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                sdmb_pkg::REG_CENTER_X:     center_x_reg     <= pwdata[sdmb_pkg::CX_W-1:0];
                sdmb_pkg::REG_CENTER_Y:     center_y_reg     <= pwdata[sdmb_pkg::CY_W-1:0];
                sdmb_pkg::REG_RADIUS:       radius_reg       <= pwdata[sdmb_pkg::RAD_W-1:0];
                sdmb_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[DIM_W-1:0];
                sdmb_pkg::REG_IMAGE_HEIGHT: image_height_reg <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            sdmb_pkg::REG_CENTER_X:     prdata = sdmb_pkg::APB_DATA_W'(center_x_reg);
            sdmb_pkg::REG_CENTER_Y:     prdata = sdmb_pkg::APB_DATA_W'(center_y_reg);
            sdmb_pkg::REG_RADIUS:       prdata = sdmb_pkg::APB_DATA_W'(radius_reg);
            sdmb_pkg::REG_IMAGE_WIDTH:  prdata = sdmb_pkg::APB_DATA_W'(image_width_reg);
            sdmb_pkg::REG_IMAGE_HEIGHT: prdata = sdmb_pkg::APB_DATA_W'(image_height_reg);
            default:                    prdata = '0;
        endcase
    end

    // Box edges: centre -/+ (radius + one pixel), truncated and clamped
    always_comb
    begin
        logic signed [SUM_W-1:0] cx;
        logic signed [SUM_W-1:0] cy;
        logic signed [SUM_W-1:0] r;
        cx = $signed(SUM_W'(center_x_reg));
        cy = $signed(SUM_W'(center_y_reg));
        r  = $signed(SUM_W'(radius_reg));
        box_next.row_lo = box_edge(cy - r - ONE_FX, last_index(image_height_reg));
        box_next.row_hi = box_edge(cy + r + ONE_FX, last_index(image_height_reg));
        box_next.col_lo = box_edge(cx - r - ONE_FX, last_index(image_width_reg));
        box_next.col_hi = box_edge(cx + r + ONE_FX, last_index(image_width_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            box_reg <= '0;
        else
            box_reg <= box_next;
    end

    assign cfg.center_x = center_x_reg;
    assign cfg.center_y = center_y_reg;
    assign cfg.radius   = radius_reg;
    assign box          = box_reg;

endmodule

`default_nettype wire

// File: sv/sdmb_isqrt.sv
// Pipelined integer square root, one result bit per register stage, with a sideband payload.
// Depends on nothing but the clock enable supplied by the caller.
`default_nettype none

module sdmb_isqrt #(
    parameter int IN_W   = 39,
    parameter int SIDE_W = 9,
    localparam int OUT_W = (IN_W + 1) / 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [IN_W-1:0]   in_radicand,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [OUT_W-1:0]       out_root,
    output logic [SIDE_W-1:0]      out_side
);

    localparam int PAD_W = 2 * OUT_W;
    localparam int REM_W = OUT_W + 3;

    logic              valid_reg [OUT_W];
    logic [REM_W-1:0]  rem_reg   [OUT_W];
    logic [OUT_W-1:0]  root_reg  [OUT_W];
    logic [PAD_W-1:0]  rad_reg   [OUT_W];
    logic [SIDE_W-1:0] side_reg  [OUT_W];

    for (genvar k = 0; k < OUT_W; k++)
    begin : g_step
        logic              valid_p;
        logic [REM_W-1:0]  rem_p;
        logic [OUT_W-1:0]  root_p;
        logic [PAD_W-1:0]  rad_p;
        logic [SIDE_W-1:0] side_p;
        logic [REM_W-1:0]  rem_s;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  rem_next;
        logic [OUT_W-1:0]  root_next;

        if (k == 0)
        begin : g_first
            assign valid_p = in_valid;
            assign rem_p   = '0;
            assign root_p  = '0;
            assign rad_p   = PAD_W'(in_radicand);
            assign side_p  = in_side;
        end
        else
        begin : g_rest
            assign valid_p = valid_reg[k-1];
            assign rem_p   = rem_reg[k-1];
            assign root_p  = root_reg[k-1];
            assign rad_p   = rad_reg[k-1];
            assign side_p  = side_reg[k-1];
        end

        // Bring down the next bit pair and try 4*root + 1
        always_comb
        begin
            rem_s = {rem_p[REM_W-3:0], rad_p[PAD_W-1 -: 2]};
            trial = REM_W'({root_p, 2'b01});
            if (rem_s >= trial)
            begin
                rem_next  = rem_s - trial;
                root_next = {root_p[OUT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_s;
                root_next = {root_p[OUT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= valid_p;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= rad_p << 2;
                side_reg[k] <= side_p;
            end
        end
    end

    assign out_valid = valid_reg[OUT_W-1];
    assign out_root  = root_reg[OUT_W-1];
    assign out_side  = side_reg[OUT_W-1];

endmodule

`default_nettype wire

// File: sv/sdmb_outbuf.sv
// Output register with one skid entry; drives the pipeline advance enable.
// Depends on sdmb_pkg and sdmb_pix_out_if.
`default_nettype none

module sdmb_outbuf (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       pipe_valid,
    input  wire logic [sdmb_pkg::PIX_W-1:0] pipe_value,
    output logic                            en,
    sdmb_pix_out_if.source                  pix_out
);

    logic                       out_valid_reg;
    logic [sdmb_pkg::PIX_W-1:0] out_value_reg;
    logic                       skid_valid_reg;
    logic [sdmb_pkg::PIX_W-1:0] skid_value_reg;
    logic                       take;
    logic                       consume;

    assign en      = !skid_valid_reg;
    assign take    = out_valid_reg && pix_out.ready;
    assign consume = en && pipe_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (consume)
        begin
            if (out_valid_reg && !take)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
                out_value_reg <= skid_value_reg;
        end
        else if (consume)
        begin
            if (out_valid_reg && !take)
                skid_value_reg <= pipe_value;
            else
                out_value_reg <= pipe_value;
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.new_value = out_value_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !pix_out.ready))
        else $error("skid entry filled without an output stall");

    a_consume_lands: assert property (@(posedge clk) disable iff (!rst_n)
        consume |=> out_valid_reg)
        else $error("pipeline result dropped");

endmodule

`default_nettype wire

// File: bench/sdmb_checker.sv
// Scoreboard for the soft disc max-blend block: tracks the register writes,
// predicts each pixel's blended value and compares the output stream.
// Depends on sdmb_pkg and the stream interfaces in sdmb_if.
`default_nettype none

module sdmb_checker
    import sdmb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic                  pready,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    sdmb_pix_in_if                     in_ch,
    sdmb_pix_out_if                    out_ch,
    output int                         fail_count,
    output int                         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] old;
        logic [PIX_W-1:0] blended;
    } pixel_note_t;

    logic [CX_W-1:0]  disc_cx;
    logic [CY_W-1:0]  disc_cy;
    logic [RAD_W-1:0] disc_r;
    logic [DIM_W-1:0] img_w;
    logic [DIM_W-1:0] img_h;

    pixel_note_t blend_queue[$];
    int          errors;

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int i = 31; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    function automatic longint clamp_dim(input logic [DIM_W-1:0] dim);
        if (dim == '0)
            return 1;
        if (dim > MAX_DIM_DEF)
            return MAX_DIM_DEF;
        return longint'(dim);
    endfunction

    // Q.8 position to pixel index, held inside 0..dim-1
    function automatic longint edge_of_box(input longint pos, input longint dim);
        longint px;
        if (pos < 0)
            return 0;
        px = pos >>> FRAC_BITS_DEF;
        return (px > dim - 1) ? dim - 1 : px;
    endfunction

    function automatic logic [PIX_W-1:0] blend_pixel(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col,
                                                     input logic [PIX_W-1:0] old);
        longint          one;
        longint          cx;
        longint          cy;
        longint          r;
        longint          row_lo;
        longint          row_hi;
        longint          col_lo;
        longint          col_hi;
        longint          dx;
        longint          dy;
        longint          radial;
        longint          u;
        longint unsigned s;
        longint unsigned b;
        one    = longint'(1) << FRAC_BITS_DEF;
        cx     = longint'(disc_cx);
        cy     = longint'(disc_cy);
        r      = longint'(disc_r);
        row_lo = edge_of_box(cy - r - one, clamp_dim(img_h));
        row_hi = edge_of_box(cy + r + one, clamp_dim(img_h));
        col_lo = edge_of_box(cx - r - one, clamp_dim(img_w));
        col_hi = edge_of_box(cx + r + one, clamp_dim(img_w));
        if (!(longint'(row) >= row_lo && longint'(row) < row_hi &&
              longint'(col) >= col_lo && longint'(col) < col_hi))
            return old;
        dx     = longint'(col) * one - cx;
        dy     = longint'(row) * one - cy;
        radial = longint'(floor_root(longint'(dx * dx + dy * dy)));
        u      = 2 * (r - radial);
        if (u < 0)
            u = 0;
        if (u > one)
            u = one;
        s = floor_root(longint'(u) << (FRAC_BITS_DEF + 8));
        b = (255 * s) >> (FRAC_BITS_DEF + 4);
        if (b > 255)
            b = 255;
        return (b > old) ? PIX_W'(b) : old;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        pixel_note_t note;
        if (!rst_n) begin
            disc_cx = '0;
            disc_cy = '0;
            disc_r  = '0;
            img_w   = DIM_RESET;
            img_h   = DIM_RESET;
            blend_queue.delete();
            errors  = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[APB_ADDR_W-1:2]))
                    REG_CENTER_X:     disc_cx = pwdata[CX_W-1:0];
                    REG_CENTER_Y:     disc_cy = pwdata[CY_W-1:0];
                    REG_RADIUS:       disc_r  = pwdata[RAD_W-1:0];
                    REG_IMAGE_WIDTH:  img_w   = pwdata[DIM_W-1:0];
                    REG_IMAGE_HEIGHT: img_h   = pwdata[DIM_W-1:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                note.row     = in_ch.pixel_row;
                note.col     = in_ch.pixel_col;
                note.old     = in_ch.old_value;
                note.blended = blend_pixel(in_ch.pixel_row, in_ch.pixel_col, in_ch.old_value);
                blend_queue.push_back(note);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (blend_queue.size() == 0)
                    report_mismatch($sformatf("new_value %0d with no pixel outstanding",
                                              out_ch.new_value));
                else begin
                    note = blend_queue.pop_front();
                    if (out_ch.new_value !== note.blended)
                        report_mismatch($sformatf(
                            "pixel (%0d,%0d) old %0d: new_value %0d, predicted %0d",
                            note.row, note.col, note.old, out_ch.new_value, note.blended));
                end
            end
            fail_count <= errors;
            pending    <= blend_queue.size();
        end
    end

endmodule

`default_nettype wire

// File: bench/tb_soft_disc_max_blend.sv
// Top of the soft disc max-blend testbench: clock, reset, register writes,
// pixel stimulus, output back-pressure and the verdict.
// Depends on sdmb_pkg, sdmb_if, the block itself and sdmb_checker.
`default_nettype none

module tb_soft_disc_max_blend;
    timeunit 1ns;
    timeprecision 1ps;

    import sdmb_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 11;
    // far beyond the pipeline latency plus the longest gap and stall
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 60;
    localparam int RANDOM_PHASES   = 7;
    localparam int PHASE_ITEMS     = 120;
    localparam int CALM_ITEMS      = 150;
    localparam int ONE_PX          = 1 << FRAC_BITS_DEF;
    localparam int CX_MAX          = (1 << CX_W) - 1;
    localparam int CY_MAX          = (1 << CY_W) - 1;
    localparam int RAD_MAX         = (1 << RAD_W) - 1;
    localparam int PIX_MAX         = (1 << PIX_W) - 1;
    localparam int ROW_MAX         = (1 << ROW_W) - 1;
    localparam int COL_MAX         = (1 << COL_W) - 1;
    localparam int DIM_FIELD_MAX   = (1 << DIM_W) - 1;

    // register slots with nothing behind them
    localparam logic [REG_IDX_W-1:0] UNMAPPED_IDX_LO = 3'd5;
    localparam logic [REG_IDX_W-1:0] UNMAPPED_IDX_HI = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;

    bit idling_on;
    int stall_left;
    int quiet_cycles;

    // disc currently programmed, used to aim pixels at it
    int cur_cx;
    int cur_cy;
    int cur_r;

    sdmb_pix_in_if  in_ch ();
    sdmb_pix_out_if out_ch ();

    soft_disc_max_blend u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pix_in  (in_ch),
        .pix_out (out_ch)
    );

    sdmb_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
        clk = 1'b0;

    always #CLK_HALF clk = ~clk;

    // Output back-pressure: drop ready for a burst of random length now and then.
    // A burst that has started runs out even once idling is switched off.
    always @(posedge clk) begin
        if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end
        else begin
            out_ch.ready <= 1'b1;
            if (idling_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 16);
        end
    end

    // Watchdog: end the run when nothing has moved for too long.
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // One register write: setup cycle, access cycle, then idle with psel low so that
    // back-to-back writes never raise and lower psel within one time step.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                             input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid and hold until every predicted pixel has come back. The extra
    // edge lets the checker's count catch up with the last input transfer.
    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Reprogram the disc; only ever done with the pipeline empty, and since every
    // pixel yields exactly one result, an empty scoreboard means an idle block.
    task automatic set_disc(input int cx, input int cy, input int r,
                            input int w, input int h);
        wait_for_results();
        write_reg(REG_CENTER_X, APB_DATA_W'(cx));
        write_reg(REG_CENTER_Y, APB_DATA_W'(cy));
        write_reg(REG_RADIUS, APB_DATA_W'(r));
        write_reg(REG_IMAGE_WIDTH, APB_DATA_W'(w));
        write_reg(REG_IMAGE_HEIGHT, APB_DATA_W'(h));
        cur_cx = cx;
        cur_cy = cy;
        cur_r  = r;
    endtask

    // Present one pixel, perhaps after a gap, and hold it until its transfer.
    task automatic send_pixel(input int row, input int col, input int old);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16))
                @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.pixel_row <= ROW_W'(row);
        in_ch.pixel_col <= COL_W'(col);
        in_ch.old_value <= PIX_W'(old);
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    function automatic int pick_dim();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return $urandom_range(MAX_DIM_DEF + 1, DIM_FIELD_MAX);
            2:       return MAX_DIM_DEF;
            3:       return 1;
            default: return $urandom_range(1, MAX_DIM_DEF);
        endcase
    endfunction

    // Random disc, mostly lying inside the image and of modest size, with the
    // odd one anywhere in the register range or at its limits.
    task automatic random_disc();
        int w;
        int h;
        int w_px;
        int h_px;
        int cx;
        int cy;
        int r;
        w    = pick_dim();
        h    = pick_dim();
        w_px = (w < 1) ? 1 : ((w > MAX_DIM_DEF) ? MAX_DIM_DEF : w);
        h_px = (h < 1) ? 1 : ((h > MAX_DIM_DEF) ? MAX_DIM_DEF : h);
        if ($urandom_range(0, 7) == 0) begin
            cx = $urandom_range(0, CX_MAX);
            cy = $urandom_range(0, CY_MAX);
        end
        else begin
            cx = $urandom_range(0, w_px * ONE_PX - 1);
            cy = $urandom_range(0, h_px * ONE_PX - 1);
        end
        case ($urandom_range(0, 9))
            0:       r = 0;
            1:       r = RAD_MAX;
            2:       r = $urandom_range(0, RAD_MAX);
            default: r = $urandom_range(0, 48 * ONE_PX);
        endcase
        set_disc(cx, cy, r, w, h);
        // a write to an empty slot must leave the disc untouched
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? UNMAPPED_IDX_LO : UNMAPPED_IDX_HI, $urandom());
    endtask

    // Three in four pixels land on or around the disc, the rest anywhere.
    task automatic send_random_pixel();
        int span;
        int row;
        int col;
        int old;
        if ($urandom_range(0, 3) != 0) begin
            span = cur_r / ONE_PX + 2;
            row  = cur_cy / ONE_PX + int'($urandom_range(0, 2 * span)) - span;
            col  = cur_cx / ONE_PX + int'($urandom_range(0, 2 * span)) - span;
            row  = (row < 0) ? 0 : ((row > ROW_MAX) ? ROW_MAX : row);
            col  = (col < 0) ? 0 : ((col > COL_MAX) ? COL_MAX : col);
        end
        else begin
            row = $urandom_range(0, ROW_MAX);
            col = $urandom_range(0, COL_MAX);
        end
        case ($urandom_range(0, 7))
            0:       old = 0;
            1:       old = PIX_MAX;
            default: old = $urandom_range(0, PIX_MAX);
        endcase
        send_pixel(row, col, old);
    endtask

    initial begin
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_ch.valid     = 1'b0;
        in_ch.pixel_row = '0;
        in_ch.pixel_col = '0;
        in_ch.old_value = '0;
        out_ch.ready    = 1'b0;
        idling_on       = 1'b1;
        stall_left      = 0;
        quiet_cycles    = 0;
        cur_cx          = 0;
        cur_cy          = 0;
        cur_r           = 0;

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: zero disc at the origin, so the top-left pixel sits in the
        // box but draws nothing.
        send_pixel(0, 0, 9);
        send_pixel(1, 1, 3);

        // Disc at (100.5, 80.25) radius 20.5 in a 200x120 image:
        // rows 58..100 and columns 79..121 form the box.
        set_disc(25728, 20544, 5248, 200, 120);
        send_pixel(80, 100, 0);        // centre, full intensity
        send_pixel(80, 100, PIX_MAX);  // old value wins on a tie
        send_pixel(58, 79, 0);         // first corner of the box
        send_pixel(57, 100, 0);        // row just above the box
        send_pixel(100, 100, 0);       // last row inside
        send_pixel(101, 100, 0);       // exclusive upper row bound
        send_pixel(80, 121, 0);        // last column inside
        send_pixel(80, 122, 0);        // exclusive upper column bound
        send_pixel(80, 78, 0);         // column just left of the box
        send_pixel(80, 79, 0);
        send_pixel(80, 120, 0);        // inside the disc near its right edge, still full intensity
        send_pixel(95, 110, 128);      // inside the disc, full intensity over a mid grey
        send_pixel(ROW_MAX, COL_MAX, 7);  // far outside the image

        // Width of zero saturates to one column and the centre sits at the far
        // corner: the box is empty. Writes to empty slots change nothing.
        set_disc(CX_MAX, CY_MAX, 1000, 0, DIM_FIELD_MAX);
        write_reg(UNMAPPED_IDX_LO, 32'h0000_0000);
        write_reg(UNMAPPED_IDX_HI, 32'hFFFF_FFFF);
        send_pixel(2046, 0, 0);
        send_pixel(0, 0, 0);
        send_pixel(ROW_MAX, COL_MAX, 200);

        // 16x16 image, disc at (15, 15): the image's last row and column stay blank.
        set_disc(15 * ONE_PX, 15 * ONE_PX, 4 * ONE_PX, 16, 16);
        send_pixel(14, 14, 0);
        send_pixel(15, 14, 0);
        send_pixel(14, 15, 0);
        send_pixel(12, 13, 40);

        // Largest radius at the origin of a full-size image.
        set_disc(0, 0, RAD_MAX, MAX_DIM_DEF, MAX_DIM_DEF);
        send_pixel(0, 0, 0);
        send_pixel(2046, 2046, 0);
        send_pixel(ROW_MAX, 0, 0);
        send_pixel(1023, 511, 0);

        // Random discs; one phase in four runs without any idling.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            random_disc();
            idling_on = ($urandom_range(0, 3) != 0);
            repeat (PHASE_ITEMS)
                send_random_pixel();
        end

        // Closing stretch at full rate on both sides.
        random_disc();
        idling_on = 1'b0;
        repeat (CALM_ITEMS)
            send_random_pixel();

        wait_for_results();
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
sv/sdmb_pkg.sv
sv/sdmb_if.sv
sv/sdmb_cfg.sv
sv/sdmb_isqrt.sv
sv/sdmb_outbuf.sv
sv/soft_disc_max_blend.sv
bench/sdmb_checker.sv
bench/tb_soft_disc_max_blend.sv
